// File: hw/rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, codes, command format and controller states.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Field widths of the request and response channels.
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned ATTR_W  = 8;
	localparam int unsigned COLOR_W = 4;
	localparam int unsigned TROW_W  = 5;
	localparam int unsigned TCOL_W  = 7;
	localparam int unsigned POS_W   = 11;
	localparam int unsigned CELL_W  = ATTR_W + CHAR_W;

	// Depth of the command queue between front end and back end.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Character codes with a control meaning.
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	// Attribute written by the power-on clear.
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

	// Tab stops sit on multiples of this value.
	localparam int unsigned TAB_STOP = 8;

	// Function codes of the request channel.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUT        = 2'd0,
		FUNC_SET_CURSOR = 2'd1,
		FUNC_CLEAR      = 2'd2,
		FUNC_READ       = 2'd3
	} func_t;

	// Decoded operations handed to the back end.
	typedef enum logic [2:0] {
		OP_PRINT,
		OP_NEWLINE,
		OP_RETURN,
		OP_TAB,
		OP_BACKSPACE,
		OP_SET_CURSOR,
		OP_CLEAR,
		OP_READ
	} op_t;

	// One queued command. Row and column are already clamped to the screen.
	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] attr;
		logic [TROW_W-1:0] row;
		logic [TCOL_W-1:0] col;
	} cmd_t;

	// Queue fill status.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Back end controller states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_FILL,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/tcw_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------

// Request channel: one console operation per request.
interface tcw_cmd_if import tcw_pkg::*;;
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [CHAR_W-1:0]  char_code;
	logic               use_colors;
	logic [COLOR_W-1:0] fg_color;
	logic [COLOR_W-1:0] bg_color;
	logic [TROW_W-1:0]  target_row;
	logic [TCOL_W-1:0]  target_col;

	modport source (
		output valid, func, char_code, use_colors, fg_color, bg_color,
		       target_row, target_col,
		input  ready
	);
	modport sink (
		input  valid, func, char_code, use_colors, fg_color, bg_color,
		       target_row, target_col,
		output ready
	);
endinterface

// Response channel: cursor state and read data for each request.
interface tcw_res_if import tcw_pkg::*;;
	logic              valid;
	logic              ready;
	logic [TROW_W-1:0] cursor_row;
	logic [TCOL_W-1:0] cursor_col;
	logic [POS_W-1:0]  cursor_position;
	logic [CHAR_W-1:0] read_char;
	logic [ATTR_W-1:0] read_attr;

	modport source (
		output valid, cursor_row, cursor_col, cursor_position, read_char, read_attr,
		input  ready
	);
	modport sink (
		input  valid, cursor_row, cursor_col, cursor_position, read_char, read_attr,
		output ready
	);
endinterface
`default_nettype wire

// File: hw/rtl/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/tcw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts requests, holds the default attribute, decodes each request into
// a command with its attribute resolved and its target clamped.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tcw_cmd_if.sink                cmd,
	input  wire logic              cfg_we,
	input  wire logic [ATTR_W-1:0] cfg_wdata,
	input  wire logic              init_done,
	input  wire q_stat_t           q_stat,
	output logic                   q_push,
	output cmd_t                   q_cmd
);

	localparam int unsigned ROW_MAX = ROWS - 1;
	localparam int unsigned COL_MAX = COLUMNS - 1;

	logic [ATTR_W-1:0] text_attr_q;

	// Default attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= RESET_ATTR;
		end else if (cfg_we) begin
			text_attr_q <= cfg_wdata;
		end
	end

	// Take a request whenever the queue has room and the power-on clear is done.
	assign cmd.ready = init_done && !q_stat.full;
	assign q_push    = cmd.valid && cmd.ready;

	// Decode the request into a queued command.
	always_comb begin
		q_cmd.ch   = cmd.char_code;
		q_cmd.attr = text_attr_q;
		q_cmd.op   = OP_PRINT;
		q_cmd.row  = (32'(cmd.target_row) > ROW_MAX) ? TROW_W'(ROW_MAX) : cmd.target_row;
		q_cmd.col  = (32'(cmd.target_col) > COL_MAX) ? TCOL_W'(COL_MAX) : cmd.target_col;
		unique case (func_t'(cmd.func))
			FUNC_PUT: begin
				if (cmd.use_colors) begin
					q_cmd.attr = {cmd.bg_color, cmd.fg_color};
				end
				unique case (cmd.char_code)
					CH_NEWLINE:   q_cmd.op = OP_NEWLINE;
					CH_RETURN:    q_cmd.op = OP_RETURN;
					CH_TAB:       q_cmd.op = OP_TAB;
					CH_BACKSPACE: q_cmd.op = OP_BACKSPACE;
					default:      q_cmd.op = OP_PRINT;
				endcase
			end
			FUNC_SET_CURSOR: q_cmd.op = OP_SET_CURSOR;
			FUNC_CLEAR:      q_cmd.op = OP_CLEAR;
			FUNC_READ:       q_cmd.op = OP_READ;
			default:         q_cmd.op = OP_PRINT;
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/tcw_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short register FIFO that decouples request decode from execution.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo import tcw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head_cmd,
	output q_stat_t   stat
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
	localparam logic [PW:0]   FULL_CNT  = (PW+1)'(QUEUE_DEPTH);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign head_cmd   = slot_q[rd_ptr_q];
	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/tcw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the cursor and the screen memory. Executes one command at a time:
// writes, cursor moves, row-by-row scroll copy, screen fill and cell reads,
// and presents the response through an output register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_t    q_cmd,
	input  wire q_stat_t q_stat,
	output logic         q_pop,
	output logic         init_done,
	tcw_res_if.source    res
);

	localparam int unsigned CELLS = ROWS * COLUMNS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned RW    = $clog2(ROWS);
	localparam int unsigned CW    = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] ROW_STEP      = AW'(COLUMNS);
	localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);
	localparam logic [CW:0]   TAB_INC       = (CW+1)'(TAB_STOP);
	localparam logic [CW:0]   TAB_ALIGN     = ~((CW+1)'(TAB_STOP - 1));
	localparam logic [CW:0]   COL_LIMIT     = (CW+1)'(COLUMNS);

	state_t state_q, state_d;

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] idx_q;
	logic          cp_pend_s1;
	logic [AW-1:0] cp_dst_s1;
	logic [ATTR_W-1:0] attr_q;
	op_t           op_q;
	logic          res_valid_q;

	logic [AW-1:0] cur_pos;
	logic [AW-1:0] tgt_pos;
	logic [CW:0]   tab_col;
	logic          at_last_row;
	logic          at_last_col;
	logic          scroll_issue;
	logic          res_load;

	logic [RW-1:0]     disp_row;
	logic [CW-1:0]     disp_col;
	logic              disp_adv;
	logic              disp_scroll;
	logic              disp_we;
	logic [AW-1:0]     disp_waddr;
	logic [CELL_W-1:0] disp_wdata;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Screen memory.
	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Linear addresses of the cursor cell and of the addressed cell.
	assign cur_pos      = AW'(row_q) * ROW_STEP + AW'(col_q);
	assign tgt_pos      = AW'(q_cmd.row) * ROW_STEP + AW'(q_cmd.col);
	assign tab_col      = ({1'b0, col_q} + TAB_INC) & TAB_ALIGN;
	assign at_last_row  = (row_q == LAST_ROW);
	assign at_last_col  = (col_q == LAST_COL);
	assign scroll_issue = (idx_q != LAST_ROW_BASE);
	assign res_load     = (state_q == ST_RESP) && (!res_valid_q || res.ready);
	assign init_done    = (state_q != ST_INIT);

	// Cursor update and cell write for the command at the queue head.
	always_comb begin
		disp_row   = row_q;
		disp_col   = col_q;
		disp_adv   = 1'b0;
		disp_we    = 1'b0;
		disp_waddr = cur_pos;
		disp_wdata = {q_cmd.attr, q_cmd.ch};
		unique case (q_cmd.op)
			OP_PRINT: begin
				disp_we = 1'b1;
				if (at_last_col) begin
					disp_col = '0;
					disp_adv = 1'b1;
				end else begin
					disp_col = col_q + CW'(1);
				end
			end
			OP_NEWLINE: begin
				disp_col = '0;
				disp_adv = 1'b1;
			end
			OP_RETURN: begin
				disp_col = '0;
			end
			OP_TAB: begin
				if (tab_col >= COL_LIMIT) begin
					disp_col = '0;
					disp_adv = 1'b1;
				end else begin
					disp_col = tab_col[CW-1:0];
				end
			end
			OP_BACKSPACE: begin
				if (col_q != '0) begin
					disp_col   = col_q - CW'(1);
					disp_we    = 1'b1;
					disp_waddr = cur_pos - AW'(1);
					disp_wdata = {q_cmd.attr, BLANK_CHAR};
				end
			end
			OP_SET_CURSOR: begin
				disp_row = RW'(q_cmd.row);
				disp_col = CW'(q_cmd.col);
			end
			OP_CLEAR: begin
				disp_row = '0;
				disp_col = '0;
			end
			OP_READ: begin
			end
			default: begin
			end
		endcase
		// Moving past the last row keeps the cursor there and scrolls instead.
		disp_scroll = disp_adv && at_last_row;
		if (disp_adv && !at_last_row) begin
			disp_row = row_q + RW'(1);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (idx_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_stat.empty) begin
					if (q_cmd.op == OP_CLEAR) begin
						state_d = ST_FILL;
					end else if (disp_scroll) begin
						state_d = ST_SCROLL;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCROLL: begin
				if (!scroll_issue) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (idx_q == LAST_CELL) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Memory and queue controls.
	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {attr_q, BLANK_CHAR};
		ram_re    = 1'b0;
		ram_raddr = tgt_pos;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {RESET_ATTR, BLANK_CHAR};
			end
			ST_IDLE: begin
				q_pop     = !q_stat.empty;
				ram_we    = !q_stat.empty && disp_we;
				ram_waddr = disp_waddr;
				ram_wdata = disp_wdata;
				ram_re    = !q_stat.empty && (q_cmd.op == OP_READ);
			end
			ST_SCROLL: begin
				// Read one row below, write back the cell that the previous read returned.
				ram_re    = scroll_issue;
				ram_raddr = idx_q + ROW_STEP;
				ram_we    = cp_pend_s1;
				ram_waddr = cp_dst_s1;
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			idx_q       <= '0;
			cp_pend_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cp_pend_s1 <= (state_q == ST_SCROLL) && scroll_issue;
			unique case (state_q)
				ST_INIT, ST_FILL: begin
					idx_q <= idx_q + AW'(1);
				end
				ST_IDLE: begin
					if (q_pop) begin
						row_q <= disp_row;
						col_q <= disp_col;
						idx_q <= '0;
					end
				end
				ST_SCROLL: begin
					if (scroll_issue) begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_RESP: begin
				end
				default: begin
				end
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Command and scroll payload registers.
	always_ff @(posedge clk) begin
		cp_dst_s1 <= idx_q;
		if (q_pop) begin
			attr_q <= q_cmd.attr;
			op_q   <= q_cmd.op;
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res.cursor_row      <= TROW_W'(row_q);
			res.cursor_col      <= TCOL_W'(col_q);
			res.cursor_position <= POS_W'(cur_pos);
			res.read_char       <= (op_q == OP_READ) ? ram_rdata[CHAR_W-1:0] : '0;
			res.read_attr       <= (op_q == OP_READ) ? ram_rdata[CELL_W-1:CHAR_W] : '0;
		end
	end

	assign res.valid = res_valid_q;

endmodule
`default_nettype wire

// File: hw/rtl/text_console_writer.sv
`default_nettype none
// A request is decoded, queued, then dispatched and answered by the back end; the queue
//   keeps taking requests while the back end works, until it is full.
// A scroll copies the screen up one row (one memory port pair copies a cell per cycle),
//   then the last row is blanked; a clear blanks the whole screen.
// After reset the screen memory is swept, every cell blanked with attribute 0x07,
//   before the first request is taken; the attribute register resets to 0x07.
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine: front end decode, command queue, back end with
// cursor, screen memory, scroll and clear sequencing.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tcw_cmd_if.sink                cmd,
	tcw_res_if.source              res,
	input  wire logic              cfg_we,
	input  wire logic [ATTR_W-1:0] cfg_wdata
);

	logic    q_push;
	logic    q_pop;
	logic    init_done;
	cmd_t    push_cmd;
	cmd_t    head_cmd;
	q_stat_t q_stat;

	// Request decode.
	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.init_done (init_done),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	// Command queue.
	tcw_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	// Execution and screen memory.
	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (head_cmd),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.init_done (init_done),
		.res       (res)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("command pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command popped from an empty queue");

	a_col_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (32'(res.cursor_col) < COLUMNS))
		else $error("cursor column outside the screen");

	a_pos_matches: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (ROWS > 32) || (res.cursor_position ==
			POS_W'(32'(res.cursor_row) * COLUMNS + 32'(res.cursor_col))))
		else $error("cursor position does not match row and column");
`endif

endmodule
`default_nettype wire

// File: verif/tcw_screen_checker.sv
// ----------------------------------------------------------------------------
// Text console screen checker
// Watches the request, response and attribute-write ports of the console
// writer. It keeps its own copy of the screen, cursor and default attribute.
// It predicts the cursor report for every accepted request and compares each
// response with the oldest prediction, one field at a time.
// ----------------------------------------------------------------------------
module tcw_screen_checker import tcw_pkg::*; #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	tcw_cmd_if                cmd,
	tcw_res_if                res,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	output int unsigned       error_count,
	output int unsigned       outstanding
);

	localparam int unsigned CELLS       = ROWS * COLUMNS;
	localparam int unsigned MAX_PRINTED = 100;

	// Cursor and read data that one request should report.
	typedef struct packed {
		logic [TROW_W-1:0] row;
		logic [TCOL_W-1:0] col;
		logic [POS_W-1:0]  pos;
		logic [CHAR_W-1:0] rd_char;
		logic [ATTR_W-1:0] rd_attr;
	} cursor_report_t;

	// Shadow copy of the console state.
	logic [CELL_W-1:0] screen [CELLS];
	int unsigned       cur_line;
	int unsigned       cur_column;
	logic [ATTR_W-1:0] default_attr;

	// Reports predicted for accepted requests, oldest first.
	cursor_report_t    pending_reports [$];

	// Prints one mismatch line (up to a limit) and counts it.
	task automatic flag_error(input string msg);
		if (error_count < MAX_PRINTED) begin
			$display("%0t ERROR %s", $time, msg);
		end
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			flag_error($sformatf("%s: got %0d, expected %0d", name, got, want));
		end
	endtask

	// Linear cell index, with row and column clamped to the screen.
	function automatic int unsigned cell_at(input int unsigned r, input int unsigned c);
		return ((r < ROWS) ? r : ROWS - 1) * COLUMNS + ((c < COLUMNS) ? c : COLUMNS - 1);
	endfunction

	function automatic void blank_screen(input logic [ATTR_W-1:0] attr);
		for (int i = 0; i < CELLS; i++) begin
			screen[i] = {attr, BLANK_CHAR};
		end
	endfunction

	// Applies one request to the shadow state and returns what it should report.
	function automatic cursor_report_t advance_console(input func_t f,
			input logic [CHAR_W-1:0] ch, input logic use_colors,
			input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
			input logic [TROW_W-1:0] trow, input logic [TCOL_W-1:0] tcol);
		cursor_report_t    rep;
		logic [ATTR_W-1:0] attr;
		logic [CELL_W-1:0] cell_word;
		rep = '0;
		case (f)
			FUNC_PUT: begin
				attr = use_colors ? {bg, fg} : default_attr;
				case (ch)
					CH_NEWLINE: begin
						cur_column = 0;
						cur_line++;
					end
					CH_RETURN: begin
						cur_column = 0;
					end
					CH_TAB: begin
						cur_column = (cur_column + TAB_STOP) & ~(TAB_STOP - 1);
						if (cur_column >= COLUMNS) begin
							cur_column = 0;
							cur_line++;
						end
					end
					CH_BACKSPACE: begin
						// Backspace at the start of a row leaves everything alone.
						if (cur_column > 0) begin
							cur_column--;
							screen[cell_at(cur_line, cur_column)] = {attr, BLANK_CHAR};
						end
					end
					default: begin
						screen[cell_at(cur_line, cur_column)] = {attr, ch};
						cur_column++;
						if (cur_column >= COLUMNS) begin
							cur_column = 0;
							cur_line++;
						end
					end
				endcase
				// Falling off the bottom scrolls up and blanks the last row
				// with the attribute of this put.
				if (cur_line >= ROWS) begin
					for (int i = 0; i < CELLS - COLUMNS; i++) begin
						screen[i] = screen[i + COLUMNS];
					end
					for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
						screen[i] = {attr, BLANK_CHAR};
					end
					cur_line = ROWS - 1;
				end
			end
			FUNC_SET_CURSOR: begin
				cur_line   = (trow < ROWS) ? trow : ROWS - 1;
				cur_column = (tcol < COLUMNS) ? tcol : COLUMNS - 1;
			end
			FUNC_CLEAR: begin
				blank_screen(default_attr);
				cur_line   = 0;
				cur_column = 0;
			end
			FUNC_READ: begin
				cell_word   = screen[cell_at(trow, tcol)];
				rep.rd_char = cell_word[CHAR_W-1:0];
				rep.rd_attr = cell_word[CELL_W-1:CHAR_W];
			end
		endcase
		rep.row = TROW_W'(cur_line);
		rep.col = TCOL_W'(cur_column);
		rep.pos = POS_W'(cur_line * COLUMNS + cur_column);
		return rep;
	endfunction

	// Track attribute writes, predict on each request, compare each response.
	always @(posedge clk or negedge arst_n) begin
		cursor_report_t want;
		if (!arst_n) begin
			blank_screen(RESET_ATTR);
			default_attr = RESET_ATTR;
			cur_line     = 0;
			cur_column   = 0;
			pending_reports.delete();
			error_count  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				default_attr = cfg_wdata;
			end
			if (cmd.valid && cmd.ready) begin
				pending_reports.push_back(advance_console(func_t'(cmd.func), cmd.char_code,
					cmd.use_colors, cmd.fg_color, cmd.bg_color, cmd.target_row,
					cmd.target_col));
			end
			if (res.valid && res.ready) begin
				if (pending_reports.size() == 0) begin
					flag_error($sformatf("response at row %0d col %0d with no request waiting",
						res.cursor_row, res.cursor_col));
				end else begin
					want = pending_reports.pop_front();
					check_field("cursor_row", 16'(res.cursor_row), 16'(want.row));
					check_field("cursor_col", 16'(res.cursor_col), 16'(want.col));
					check_field("cursor_position", 16'(res.cursor_position),
						16'(want.pos));
					check_field("read_char", 16'(res.read_char), 16'(want.rd_char));
					check_field("read_attr", 16'(res.read_attr), 16'(want.rd_attr));
				end
			end
			outstanding <= pending_reports.size();
		end
	end

endmodule

// File: verif/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console requests and attribute writes into the writer while a
// screen checker beside it predicts and compares every response. A short
// directed sequence covers the control characters, line end, scrolling,
// clamping and clear; several phases of random requests follow, each under
// its own default attribute, with random idling on both channels outside one steady phase.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int unsigned COLUMNS         = 80;
	localparam int unsigned ROWS            = 25;
	localparam int unsigned PHASES          = 4;
	localparam int unsigned ITEMS_PER_PHASE = 160;
	localparam int unsigned IDLE_PCT        = 8;
	localparam int unsigned DRAIN_CYCLES    = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;
	logic              steady;
	int unsigned       error_count;
	int unsigned       outstanding;

	tcw_cmd_if cmd_ch ();
	tcw_res_if res_ch ();

	text_console_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch.sink),
		.res       (res_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tcw_screen_checker #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_screen_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	// Clock with a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Response side: stalls now and then, except during the steady stretch.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Presents one request, after an occasional gap, and waits until it is taken.
	task automatic send_request(input func_t f, input logic [CHAR_W-1:0] ch,
			input logic use_colors, input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg, input logic [TROW_W-1:0] row,
			input logic [TCOL_W-1:0] col);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.func       <= f;
		cmd_ch.char_code  <= ch;
		cmd_ch.use_colors <= use_colors;
		cmd_ch.fg_color   <= fg;
		cmd_ch.bg_color   <= bg;
		cmd_ch.target_row <= row;
		cmd_ch.target_col <= col;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
	endtask

	// Fields that a request does not use carry random values.
	task automatic put_glyph(input logic [CHAR_W-1:0] ch, input logic use_colors,
			input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
		send_request(FUNC_PUT, ch, use_colors, fg, bg, TROW_W'($urandom), TCOL_W'($urandom));
	endtask

	task automatic place_cursor(input logic [TROW_W-1:0] row, input logic [TCOL_W-1:0] col);
		send_request(FUNC_SET_CURSOR, CHAR_W'($urandom), 1'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), row, col);
	endtask

	task automatic peek_cell(input logic [TROW_W-1:0] row, input logic [TCOL_W-1:0] col);
		send_request(FUNC_READ, CHAR_W'($urandom), 1'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), row, col);
	endtask

	task automatic wipe_screen();
		send_request(FUNC_CLEAR, CHAR_W'($urandom), 1'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), TROW_W'($urandom), TCOL_W'($urandom));
	endtask

	// Stops sending and waits until every predicted response has come back.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		logic [ATTR_W-1:0] phase_attr [PHASES];
		logic [CHAR_W-1:0] glyph;
		int                roll;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.func       <= FUNC_PUT;
		cmd_ch.char_code  <= '0;
		cmd_ch.use_colors <= 1'b0;
		cmd_ch.fg_color   <= '0;
		cmd_ch.bg_color   <= '0;
		cmd_ch.target_row <= '0;
		cmd_ch.target_col <= '0;
		steady = 1'b0;
		phase_attr[0] = 8'h00;
		phase_attr[1] = 8'hFF;
		phase_attr[2] = ATTR_W'($urandom_range(1, 254));
		phase_attr[3] = ATTR_W'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset attribute.
		peek_cell(0, 0);
		peek_cell(31, 127);
		put_glyph(8'h41, 1'b0, 4'h0, 4'h0);
		put_glyph(8'hFF, 1'b1, 4'hF, 4'hF);
		put_glyph(8'h00, 1'b1, 4'h0, 4'h0);
		put_glyph(CH_BACKSPACE, 1'b1, 4'h4, 4'hA);
		peek_cell(0, 2);
		place_cursor(0, 0);
		put_glyph(CH_BACKSPACE, 1'b0, 4'h0, 4'h0);
		put_glyph(CH_TAB, 1'b0, 4'h0, 4'h0);
		place_cursor(3, 75);
		put_glyph(CH_TAB, 1'b0, 4'h0, 4'h0);
		put_glyph(8'h78, 1'b0, 4'h0, 4'h0);
		put_glyph(CH_RETURN, 1'b0, 4'h0, 4'h0);
		put_glyph(CH_NEWLINE, 1'b0, 4'h0, 4'h0);
		// Write into the bottom right corner: wraps and scrolls the screen.
		place_cursor(31, 127);
		put_glyph(8'h5A, 1'b1, 4'h1, 4'hE);
		peek_cell(23, 79);
		peek_cell(24, 40);
		peek_cell(3, 0);
		// Tab and newline on the last row scroll as well.
		place_cursor(24, 79);
		put_glyph(CH_TAB, 1'b0, 4'h0, 4'h0);
		put_glyph(CH_NEWLINE, 1'b1, 4'h3, 4'hC);
		wipe_screen();
		peek_cell(12, 40);
		settle();

		// Random phases, each under its own default attribute.
		for (int p = 0; p < PHASES; p++) begin
			cfg_we    <= 1'b1;
			cfg_wdata <= phase_attr[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			steady = (p == 2);
			wipe_screen();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < 7) begin
					place_cursor(TROW_W'($urandom_range(31)), TCOL_W'($urandom_range(127)));
				end else if (roll < 19) begin
					// Bias some reads toward the bottom rows that scrolling touches.
					if ($urandom_range(99) < 30) begin
						peek_cell(TROW_W'($urandom_range(22, 31)), TCOL_W'($urandom_range(127)));
					end else begin
						peek_cell(TROW_W'($urandom_range(31)), TCOL_W'($urandom_range(127)));
					end
				end else if (roll < 20) begin
					wipe_screen();
				end else begin
					roll = $urandom_range(99);
					if (roll < 8) begin
						glyph = CH_NEWLINE;
					end else if (roll < 13) begin
						glyph = CH_TAB;
					end else if (roll < 18) begin
						glyph = CH_BACKSPACE;
					end else if (roll < 22) begin
						glyph = CH_RETURN;
					end else begin
						glyph = CHAR_W'($urandom_range(255));
					end
					put_glyph(glyph, $urandom_range(99) < 30, COLOR_W'($urandom_range(15)),
						COLOR_W'($urandom_range(15)));
				end
			end
			settle();
			steady = 1'b0;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && outstanding == 0) begin
			$display("text_console_writer: match");
		end else begin
			$display("text_console_writer: mismatch");
		end
		$finish;
	end

	// Timeout well beyond the slowest correct run.
	initial begin
		#16_000_000;
		$display("text_console_writer: mismatch");
		$finish;
	end

endmodule
